// ----- src/tgc_pkg.sv -----
// Package for the touch gesture classifier: poll and event beat types,
// event codes, register indexes and reset values, timing/threshold constants and the divide-by-five reciprocal.
// No dependencies.
package tgc_pkg;

	// One poll from the panel and boot button
	typedef struct packed {
		logic        boot_pressed;
		logic        touch_valid;
		logic [15:0] touch_x;
		logic [15:0] touch_y;
		logic [31:0] now_ms;
	} poll_t;

	// One classified event
	typedef struct packed {
		logic [3:0] event_code;
		logic       last;
	} ev_t;

	// Results of one poll, held until its last beat has gone out
	typedef struct packed {
		logic [3:0] code0;
		logic [3:0] code1;
		logic       two;
	} ev_pair_t;

	// Event codes
	localparam logic [3:0] EV_BACK    = 4'd0;
	localparam logic [3:0] EV_NEXT    = 4'd1;
	localparam logic [3:0] EV_LEFT    = 4'd2;
	localparam logic [3:0] EV_RIGHT   = 4'd3;
	localparam logic [3:0] EV_UP_SW   = 4'd4;
	localparam logic [3:0] EV_DOWN_SW = 4'd5;
	localparam logic [3:0] EV_TAP     = 4'd6;
	localparam logic [3:0] EV_UP      = 4'd7;
	localparam logic [3:0] EV_DOWN    = 4'd8;
	localparam logic [3:0] EV_ENTER   = 4'd9;
	localparam logic [3:0] EV_MENU    = 4'd10;

	// Register indexes
	localparam logic [1:0] CFG_GESTURE_MODE  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd2;

	// Register reset values
	localparam logic        GESTURE_MODE_RST  = 1'b1;
	localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd320;
	localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd240;

	// Timing in ms and distances in pixels
	localparam logic [31:0] RELEASE_GAP_MS  = 32'd70;
	localparam logic [31:0] HOLDOFF_MS      = 32'd180;
	localparam logic [31:0] TAP_MAX_HELD_MS = 32'd700;
	localparam logic [31:0] ZONE_HOLDOFF_MS = 32'd220;
	localparam logic [16:0] SWIPE_MIN       = 17'd55;
	localparam logic [16:0] SWIPE_MARGIN    = 17'd20;
	localparam logic [15:0] TAP_MAX_MOVE    = 16'd35;

	// Divide by five: (n * RECIP5) >> RECIP5_SHIFT is exact for n < 2^18
	localparam logic [15:0] RECIP5       = 16'd52429;
	localparam int          RECIP5_SHIFT = 18;

endpackage

// ----- src/touch_gesture_classifier_core.sv -----
// Touch gesture classifier, top level.
// A poll is registered in the input stage, then its events in the result queue.
// Throughput: one poll per cycle while no poll yields two events and ev is not stalled;
// a poll with a boot event and a touch event holds the event port for two beats.
// Reset (arst_n low): all tracking state cleared, gesture mode on, 320 x 240 screen.
// Depends on tgc_pkg.
module touch_gesture_classifier_core import tgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        poll_valid,
	output logic        poll_stall,
	input  poll_t       poll,
	output logic        ev_valid,
	input  logic        ev_stall,
	output ev_t         ev,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers
	logic        gesture_mode_q;
	logic [15:0] screen_width_q;
	logic [15:0] screen_height_q;

	// Zone bounds derived from the screen size
	logic [15:0] y_top_q, y_bot_q, x_left_q, x_right_q;

	// Input stage
	logic  s1_valid_q;
	poll_t poll_s1;

	// Tracking state
	logic        boot_was_pressed_q, contact_active_q;
	logic [15:0] start_x_q, start_y_q, recent_x_q, recent_y_q;
	logic [31:0] contact_start_ms_q, last_sample_ms_q, last_event_ms_q;

	// Result queue: two entries of up to two events each
	ev_pair_t   ent_q [2];
	logic       wr_ptr_q, rd_ptr_q, sub_q;
	logic [1:0] ent_cnt_q;

	logic proc;
	logic beat, beat_last;
	logic push;

	// Classification outputs
	logic       boot_ev, touch_ev;
	logic [3:0] boot_code, touch_code;
	logic       release_now, holdoff_ok, zone_ok, gest_event;
	logic [15:0] adx, ady;
	logic [15:0] big, sml;
	logic [31:0] held;
	ev_pair_t   pair;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gesture_mode_q  <= GESTURE_MODE_RST;
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GESTURE_MODE:  gesture_mode_q  <= cfg_data[0];
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zone bounds, refreshed every cycle from the size registers
	logic [31:0] h5_prod;
	logic [33:0] h45_prod;
	logic [17:0] w3;
	assign h5_prod  = {16'd0, screen_height_q} * {16'd0, RECIP5};
	assign h45_prod = {16'd0, screen_height_q, 2'b00} * {18'd0, RECIP5};
	assign w3       = {2'b00, screen_width_q} + {1'b0, screen_width_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_top_q   <= 16'd48;
			y_bot_q   <= 16'd192;
			x_left_q  <= 16'd80;
			x_right_q <= 16'd240;
		end else begin
			y_top_q   <= {2'b00, h5_prod[RECIP5_SHIFT +: 14]};
			y_bot_q   <= h45_prod[RECIP5_SHIFT +: 16];
			x_left_q  <= {2'b00, screen_width_q[15:2]};
			x_right_q <= w3[17:2];
		end
	end

	// Input stage: hold the poll while the queue is full
	assign proc       = s1_valid_q && (ent_cnt_q != 2'd2);
	assign poll_stall = s1_valid_q && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!poll_stall) begin
			s1_valid_q <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && !poll_stall) begin
			poll_s1 <= poll;
		end
	end

	// Classify the staged poll against the tracking state
	always_comb begin
		boot_ev   = poll_s1.boot_pressed && !boot_was_pressed_q;
		boot_code = gesture_mode_q ? EV_NEXT : EV_BACK;

		adx  = (recent_x_q >= start_x_q) ? recent_x_q - start_x_q : start_x_q - recent_x_q;
		ady  = (recent_y_q >= start_y_q) ? recent_y_q - start_y_q : start_y_q - recent_y_q;
		big  = (adx > ady) ? adx : ady;
		sml  = (adx > ady) ? ady : adx;
		held = poll_s1.now_ms - contact_start_ms_q;

		release_now = !poll_s1.touch_valid && gesture_mode_q && contact_active_q &&
			((poll_s1.now_ms - last_sample_ms_q) >= RELEASE_GAP_MS);
		holdoff_ok  = (poll_s1.now_ms - last_event_ms_q) >= HOLDOFF_MS;
		zone_ok     = poll_s1.touch_valid && !gesture_mode_q &&
			((poll_s1.now_ms - last_event_ms_q) >= ZONE_HOLDOFF_MS);
		gest_event  = release_now && holdoff_ok;

		touch_ev   = 1'b0;
		touch_code = EV_MENU;
		if (gest_event) begin
			if ({1'b0, big} >= SWIPE_MIN && {1'b0, big} > ({1'b0, sml} + SWIPE_MARGIN)) begin
				touch_ev = 1'b1;
				if (adx > ady) begin
					touch_code = (recent_x_q < start_x_q) ? EV_LEFT : EV_RIGHT;
				end else begin
					touch_code = (recent_y_q < start_y_q) ? EV_UP_SW : EV_DOWN_SW;
				end
			end else if (held <= TAP_MAX_HELD_MS && adx <= TAP_MAX_MOVE &&
					ady <= TAP_MAX_MOVE) begin
				touch_ev   = 1'b1;
				touch_code = EV_TAP;
			end
		end else if (zone_ok) begin
			touch_ev = 1'b1;
			if (poll_s1.touch_y < y_top_q) begin
				touch_code = EV_UP;
			end else if (poll_s1.touch_y > y_bot_q) begin
				touch_code = EV_DOWN;
			end else if (poll_s1.touch_x < x_left_q) begin
				touch_code = EV_BACK;
			end else if (poll_s1.touch_x > x_right_q) begin
				touch_code = EV_ENTER;
			end else begin
				touch_code = EV_MENU;
			end
		end

		// Boot event goes first
		if (boot_ev) begin
			pair.code0 = boot_code;
			pair.code1 = touch_code;
			pair.two   = touch_ev;
		end else begin
			pair.code0 = touch_code;
			pair.code1 = touch_code;
			pair.two   = 1'b0;
		end
	end

	// Tracking state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_was_pressed_q <= 1'b0;
			contact_active_q   <= 1'b0;
			start_x_q          <= '0;
			start_y_q          <= '0;
			recent_x_q         <= '0;
			recent_y_q         <= '0;
			contact_start_ms_q <= '0;
			last_sample_ms_q   <= '0;
			last_event_ms_q    <= '0;
		end else if (proc) begin
			boot_was_pressed_q <= poll_s1.boot_pressed;
			if (release_now) begin
				contact_active_q <= 1'b0;
			end
			if (gest_event || zone_ok) begin
				last_event_ms_q <= poll_s1.now_ms;
			end
			if (poll_s1.touch_valid && gesture_mode_q) begin
				if (!contact_active_q) begin
					start_x_q          <= poll_s1.touch_x;
					start_y_q          <= poll_s1.touch_y;
					contact_start_ms_q <= poll_s1.now_ms;
					contact_active_q   <= 1'b1;
				end
				recent_x_q       <= poll_s1.touch_x;
				recent_y_q       <= poll_s1.touch_y;
				last_sample_ms_q <= poll_s1.now_ms;
			end
		end
	end

	// Result queue
	assign push      = proc && (boot_ev || touch_ev);
	assign ev_valid  = (ent_cnt_q != 2'd0);
	assign ev.event_code = sub_q ? ent_q[rd_ptr_q].code1 : ent_q[rd_ptr_q].code0;
	assign ev.last   = sub_q || !ent_q[rd_ptr_q].two;
	assign beat      = ev_valid && !ev_stall;
	assign beat_last = beat && ev.last;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			sub_q     <= 1'b0;
			ent_cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (beat_last) begin
				rd_ptr_q <= !rd_ptr_q;
				sub_q    <= 1'b0;
			end else if (beat) begin
				sub_q <= 1'b1;
			end
			case ({push, beat_last})
				2'b10:   ent_cnt_q <= ent_cnt_q + 2'd1;
				2'b01:   ent_cnt_q <= ent_cnt_q - 2'd1;
				default: ent_cnt_q <= ent_cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	// Queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n) ent_cnt_q != 2'd3)
		else $error("result queue count out of range");

	// Second beat only of a two-event entry that is present
	assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (ev_valid && ent_q[rd_ptr_q].two))
		else $error("second beat without a second event");

	// A contact opens only on a processed touch in gesture mode
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(contact_active_q) |-> $past(proc && poll_s1.touch_valid && gesture_mode_q))
		else $error("contact opened without a touch");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench for touch_gesture_classifier_core: drives polls and register writes,
// predicts the events of each accepted poll and checks every event beat against them.
// Depends on tgc_pkg and the core.
module tb;
	import tgc_pkg::*;

	// Classifier thresholds, in ms and pixels
	localparam logic [31:0] LIFT_GAP_MS   = 32'd70;
	localparam logic [31:0] EVENT_GAP_MS  = 32'd180;
	localparam logic [31:0] TAP_HELD_MS   = 32'd700;
	localparam logic [31:0] ZONE_GAP_MS   = 32'd220;
	localparam int          SWIPE_MIN_PX  = 55;
	localparam int          SWIPE_LEAD_PX = 20;
	localparam int          TAP_MOVE_PX   = 35;

	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_POLLS  = 225;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        poll_valid = 1'b0;
	logic        poll_stall;
	poll_t       poll = '0;
	logic        ev_valid;
	logic        ev_stall = 1'b0;
	ev_t         ev;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_GESTURE_MODE;
	logic [15:0] cfg_data = '0;

	touch_gesture_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll_valid(poll_valid),
		.poll_stall(poll_stall),
		.poll      (poll),
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.ev        (ev),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the registers and tracking state
	logic        mode_gesture = 1'b1;
	logic [15:0] width_px     = 16'd320;
	logic [15:0] height_px    = 16'd240;
	logic        btn_prev     = 1'b0;
	logic        touching     = 1'b0;
	logic [15:0] org_x = '0, org_y = '0, cur_x = '0, cur_y = '0;
	logic [31:0] touch_t0 = '0, sample_t = '0, event_t = '0;

	poll_t polls_pending[$];
	ev_t   events_due[$];

	int    errors = 0;
	int    quiet_cycles = 0;
	int    idle_pct = 0;
	int    stall_pct = 0;
	logic  hold_req = 1'b0;
	logic  hold_served = 1'b0;
	int    hold_left = 0;
	logic  offer_next;

	// Stimulus generation state
	logic        btn = 1'b0;
	logic [31:0] clk_ms = '0;

	int ph_mode[8]   = '{1, 0, 1, 0, 0, 1, 0, 1};
	int ph_width[8]  = '{320, 320, 65535, 65535, 1, 1, 0, 0};
	int ph_height[8] = '{240, 240, 65535, 1, 1, 65535, 0, 0};
	int ph_idle[8]   = '{0, 88, 0, 31, 0, 88, 0, 31};
	int ph_stall[8]  = '{0, 0, 88, 31, 0, 0, 88, 31};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic flag_error(input string what);
		if (errors < 50)
			$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Work out the events caused by one accepted poll
	task automatic classify_poll(input poll_t p);
		logic [3:0] codes[2];
		int         n;
		int         adx, ady, big, lit;
		logic [31:0] held, w, h;
		ev_t        e;
		n = 0;
		if (p.boot_pressed && !btn_prev) begin
			codes[n] = mode_gesture ? EV_NEXT : EV_BACK;
			n++;
		end
		btn_prev = p.boot_pressed;
		if (!p.touch_valid) begin
			// lift-off: classify once the contact has gone quiet
			if (mode_gesture && touching && (p.now_ms - sample_t) >= LIFT_GAP_MS) begin
				if ((p.now_ms - event_t) >= EVENT_GAP_MS) begin
					adx  = (cur_x >= org_x) ? int'(cur_x - org_x) : int'(org_x - cur_x);
					ady  = (cur_y >= org_y) ? int'(cur_y - org_y) : int'(org_y - cur_y);
					big  = (adx > ady) ? adx : ady;
					lit  = (adx > ady) ? ady : adx;
					held = p.now_ms - touch_t0;
					if (big >= SWIPE_MIN_PX && big > lit + SWIPE_LEAD_PX) begin
						if (adx > ady)
							codes[n] = (cur_x < org_x) ? EV_LEFT : EV_RIGHT;
						else
							codes[n] = (cur_y < org_y) ? EV_UP_SW : EV_DOWN_SW;
						n++;
					end else if (held <= TAP_HELD_MS && adx <= TAP_MOVE_PX &&
					             ady <= TAP_MOVE_PX) begin
						codes[n] = EV_TAP;
						n++;
					end
					event_t = p.now_ms;
				end
				touching = 1'b0;
			end
		end else if (mode_gesture) begin
			if (!touching) begin
				org_x    = p.touch_x;
				org_y    = p.touch_y;
				touch_t0 = p.now_ms;
				touching = 1'b1;
			end
			cur_x    = p.touch_x;
			cur_y    = p.touch_y;
			sample_t = p.now_ms;
		end else if ((p.now_ms - event_t) >= ZONE_GAP_MS) begin
			// zone mapping, rate limited
			w = {16'd0, width_px};
			h = {16'd0, height_px};
			event_t = p.now_ms;
			if (p.touch_y < h / 5)                codes[n] = EV_UP;
			else if (p.touch_y > (h * 4) / 5)     codes[n] = EV_DOWN;
			else if (p.touch_x < w / 4)           codes[n] = EV_BACK;
			else if (p.touch_x > (w * 3) / 4)     codes[n] = EV_ENTER;
			else                                  codes[n] = EV_MENU;
			n++;
		end
		for (int k = 0; k < n; k++) begin
			e.event_code = codes[k];
			e.last = (k == n - 1);
			events_due.push_back(e);
		end
	endtask

	// Poll driver: new beat only when the last one has gone
	always @(posedge clk) begin
		if (arst_n) begin
			offer_next = poll_valid;
			if (poll_valid && !poll_stall) begin
				classify_poll(poll);
				offer_next = 1'b0;
			end
			if (!offer_next && polls_pending.size() != 0 &&
			    $urandom_range(99) >= idle_pct) begin
				poll <= polls_pending.pop_front();
				offer_next = 1'b1;
			end
			poll_valid <= offer_next;
		end
	end

	task automatic check_event(input ev_t got);
		ev_t want;
		if (events_due.size() == 0) begin
			flag_error($sformatf("event code %0d with nothing due", got.event_code));
		end else begin
			want = events_due.pop_front();
			if (got.event_code !== want.event_code)
				flag_error($sformatf("event_code %0d, wanted %0d",
				                     got.event_code, want.event_code));
			if (got.last !== want.last)
				flag_error($sformatf("last %0b, wanted %0b", got.last, want.last));
		end
	endtask

	// Event monitor and receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (ev_valid && !ev_stall)
				check_event(ev);
			if (hold_req && !hold_served) begin
				hold_left   = HOLD_CYCLES;
				hold_served = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				ev_stall <= 1'b1;
			end else begin
				ev_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((poll_valid && !poll_stall) || (ev_valid && !ev_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_GESTURE_MODE:  mode_gesture = val[0];
			CFG_SCREEN_WIDTH:  width_px = val;
			CFG_SCREEN_HEIGHT: height_px = val;
			default: ;
		endcase
	endtask

	// Wait for every poll to go in and every event to come out, then let the pipe empty
	task automatic settle();
		do @(negedge clk);
		while (polls_pending.size() != 0 || poll_valid || events_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_poll(input logic b, input logic v, input logic [15:0] x,
	                        input logic [15:0] y, input logic [31:0] t);
		poll_t p;
		p.boot_pressed = b;
		p.touch_valid  = v;
		p.touch_x      = x;
		p.touch_y      = y;
		p.now_ms       = t;
		polls_pending.push_back(p);
	endtask

	task automatic wiggle_button();
		if ($urandom_range(7) == 0)
			btn = ~btn;
	endtask

	// One contact: a few samples along a line, then lift-off
	task automatic gen_contact();
		int kind, n, dx, dy, sx, sy, ox, oy;
		clk_ms += $urandom_range(300);
		kind = $urandom_range(3);
		case (kind)
			0: begin dx = $urandom_range(40, 200); dy = $urandom_range(60); end
			1: begin dx = $urandom_range(60); dy = $urandom_range(40, 200); end
			2: begin dx = $urandom_range(40); dy = $urandom_range(40); end
			default: begin dx = $urandom_range(90); dy = $urandom_range(90); end
		endcase
		if ($urandom_range(1)) dx = -dx;
		if ($urandom_range(1)) dy = -dy;
		sx = $urandom_range(200, 65335);
		sy = $urandom_range(200, 65335);
		n  = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				clk_ms += ($urandom_range(4) == 0) ? $urandom_range(70, 250)
				                                   : $urandom_range(1, 69);
			ox = (n > 1) ? dx * i / (n - 1) : 0;
			oy = (n > 1) ? dy * i / (n - 1) : 0;
			wiggle_button();
			add_poll(btn, 1'b1, 16'(sx + ox), 16'(sy + oy), clk_ms);
			// a quiet poll too soon to count as lift-off
			if ($urandom_range(5) == 0) begin
				clk_ms += $urandom_range(1, 69);
				add_poll(btn, 1'b0, 16'($urandom), 16'($urandom), clk_ms);
			end
		end
		clk_ms += ($urandom_range(3) == 0) ? 70 : $urandom_range(70, 130);
		wiggle_button();
		add_poll(btn, 1'b0, 16'($urandom), 16'($urandom), clk_ms);
	endtask

	// Zone-mode touch spread over and a little past the screen
	task automatic gen_zone();
		int x, y, xmax, ymax;
		case ($urandom_range(3))
			0: clk_ms += 219;
			1: clk_ms += 220;
			default: clk_ms += $urandom_range(400);
		endcase
		xmax = int'(width_px) + int'(width_px) / 8;
		ymax = int'(height_px) + int'(height_px) / 8;
		x = (xmax > 65535) ? 65535 : xmax;
		y = (ymax > 65535) ? 65535 : ymax;
		x = $urandom_range(x);
		y = $urandom_range(y);
		wiggle_button();
		add_poll(btn, $urandom_range(5) != 0, 16'(x), 16'(y), clk_ms);
	endtask

	task automatic gen_noise();
		logic [31:0] t;
		t = ($urandom_range(3) == 0) ? $urandom : clk_ms + $urandom_range(500);
		clk_ms = t;
		btn = 1'($urandom_range(1));
		add_poll(btn, 1'($urandom_range(1)), 16'($urandom), 16'($urandom), t);
	endtask

	task automatic fill_phase(input int count);
		int target;
		target = polls_pending.size() + count;
		while (polls_pending.size() < target) begin
			if ($urandom_range(99) < 12) gen_noise();
			else if (mode_gesture)       gen_contact();
			else                         gen_zone();
		end
	endtask

	initial begin
		int w, h;
		// Gesture mode at reset: boot edge, boot held, tap, lift gap one short
		add_poll(1'b1, 1'b0, 16'd0, 16'd0, 32'd10);
		add_poll(1'b1, 1'b1, 16'd100, 16'd100, 32'd1000);
		add_poll(1'b0, 1'b1, 16'd110, 16'd105, 32'd1030);
		add_poll(1'b0, 1'b0, 16'd0, 16'd0, 32'd1099);
		add_poll(1'b0, 1'b0, 16'd0, 16'd0, 32'd1100);
		// swipe inside the holdoff: dropped
		add_poll(1'b0, 1'b1, 16'd200, 16'd100, 32'd1150);
		add_poll(1'b0, 1'b1, 16'd100, 16'd100, 32'd1200);
		add_poll(1'b0, 1'b0, 16'd0, 16'd0, 32'd1270);
		// swipe right with a boot edge on the same poll: two events
		add_poll(1'b0, 1'b1, 16'd100, 16'd100, 32'd1400);
		add_poll(1'b0, 1'b1, 16'd200, 16'd110, 32'd1450);
		add_poll(1'b1, 1'b0, 16'd0, 16'd0, 32'd1520);
		// swipe up, swipe down
		add_poll(1'b0, 1'b1, 16'd100, 16'd300, 32'd1800);
		add_poll(1'b0, 1'b1, 16'd100, 16'd200, 32'd1850);
		add_poll(1'b0, 1'b0, 16'd0, 16'd0, 32'd1930);
		add_poll(1'b0, 1'b1, 16'd100, 16'd100, 32'd2200);
		add_poll(1'b0, 1'b1, 16'd100, 16'd300, 32'd2250);
		add_poll(1'b0, 1'b0, 16'd0, 16'd0, 32'd2330);
		// too far for a tap, not clear enough for a swipe
		add_poll(1'b0, 1'b1, 16'd0, 16'd0, 32'd2600);
		add_poll(1'b0, 1'b1, 16'd60, 16'd50, 32'd2650);
		add_poll(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 32'd2720);
		// held too long, across the timestamp wrap, at the edge of the panel
		add_poll(1'b0, 1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FF00);
		add_poll(1'b0, 1'b1, 16'd65500, 16'd30, 32'h0000_01F0);
		add_poll(1'b0, 1'b0, 16'd0, 16'd0, 32'h0000_0240);
		// contact left open across the mode change
		add_poll(1'b0, 1'b1, 16'd5, 16'd5, 32'h0000_0400);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// Zone mode on the reset screen: every zone, one touch just inside the rate limit
		write_reg(CFG_GESTURE_MODE, 16'd0);
		add_poll(1'b1, 1'b1, 16'd160, 16'd10, 32'd4096);
		add_poll(1'b0, 1'b1, 16'd160, 16'd230, 32'd4315);
		add_poll(1'b0, 1'b1, 16'd160, 16'd230, 32'd4316);
		add_poll(1'b0, 1'b1, 16'd10, 16'd120, 32'd4536);
		add_poll(1'b0, 1'b1, 16'd300, 16'd120, 32'd4756);
		add_poll(1'b0, 1'b1, 16'd160, 16'd120, 32'd4976);
		settle();

		// Back to gestures: the stale contact is released
		write_reg(CFG_GESTURE_MODE, 16'd1);
		add_poll(1'b0, 1'b0, 16'd0, 16'd0, 32'd5200);
		settle();
		clk_ms = 32'd5200;
		btn = 1'b0;

		// Random phases over register settings, idling patterns and receiver stall patterns
		for (int ph = 0; ph < 8; ph++) begin
			w = (ph_width[ph] == 0) ? $urandom_range(1, 65535) : ph_width[ph];
			h = (ph_height[ph] == 0) ? $urandom_range(1, 65535) : ph_height[ph];
			write_reg(CFG_GESTURE_MODE, 16'(ph_mode[ph]));
			write_reg(CFG_SCREEN_WIDTH, 16'(w));
			write_reg(CFG_SCREEN_HEIGHT, 16'(h));
			idle_pct  = ph_idle[ph];
			stall_pct = ph_stall[ph];
			if (ph == 5)
				clk_ms = 32'hFFFF_F000;
			fill_phase(PHASE_POLLS);
			// long receiver hold while polls keep coming
			if (ph == 0)
				hold_req <= 1'b1;
			settle();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- touch_gesture_classifier_core.f -----
src/tgc_pkg.sv
src/touch_gesture_classifier_core.sv
test/tb.sv
